>>> hw/rtl/pvd_pkg.sv
// ============================================================================
// pvd_pkg
// Shared types and constants for the pixel vector distance block.
// ============================================================================
`default_nettype none

package pvd_pkg;

    // Longest vector whose total is guaranteed to stay within the range limits.
    localparam int MAX_LEN = 64;

    localparam int PIXEL_W = 8;
    localparam int DIFF_W  = PIXEL_W + 1;
    localparam int SQ_W    = 2 * PIXEL_W;
    localparam int DIST_W  = 23;
    localparam int TOTAL_W = 24;
    localparam int SUM_W   = TOTAL_W + 1;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int METRIC_W = 2;

    localparam logic signed [SUM_W-1:0] DIST_HIGH = SUM_W'(MAX_LEN * 65025);
    localparam logic signed [SUM_W-1:0] DIST_LOW  = -SUM_W'(MAX_LEN * 255);

    typedef enum logic [METRIC_W-1:0] {
        METRIC_MANHATTAN = 2'd0,
        METRIC_SIGNED    = 2'd1,
        METRIC_SQUARED   = 2'd2,
        METRIC_CHEBYSHEV = 2'd3
    } t_metric;

    typedef enum logic [0:0] {
        REG_METRIC = 1'b0
    } t_reg_index;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_a;
        logic [PIXEL_W-1:0] pixel_b;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [PIXEL_W-1:0]       mag;
        logic [SQ_W-1:0]          sq;
        logic                     last;
    } t_term;

endpackage

`default_nettype wire

>>> hw/rtl/pixel_vector_distance_top.sv
// ============================================================================
// pixel_vector_distance_top
// Accumulates a Manhattan, signed, squared Euclidean or Chebyshev distance
// between two streamed pixel vectors and emits it on the last pair.
// ============================================================================
// The last pair passes the input, term and output registers in order.
// Throughput: one pair per cycle while no result is held up at the output;
// the accumulator closes its loop with the squaring done one stage earlier.
// Reset clears the metric register to Manhattan, the running total and all
// valid flags. No clearing pass is needed.
`default_nettype none

module pixel_vector_distance_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration port
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [pvd_pkg::ADDR_W-1:0]      paddr,
    input  wire [pvd_pkg::DATA_W-1:0]      pwdata,
    output logic [pvd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    // pixel pair stream
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [pvd_pkg::PIXEL_W-1:0]     i_pixel_a,
    input  wire [pvd_pkg::PIXEL_W-1:0]     i_pixel_b,
    input  wire                            i_last,
    // distance stream
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic signed [pvd_pkg::DIST_W-1:0] o_distance
);
    import pvd_pkg::*;

    t_metric                    r_metric;
    logic                       r_in_v;
    t_in_item                   r_in;
    logic                       r_term_v;
    t_term                      r_term;
    logic signed [TOTAL_W-1:0]  r_total;
    logic                       r_out_v;
    logic signed [DIST_W-1:0]   r_dist;

    logic                       out_free;
    logic                       term_take;
    logic                       term_load;
    logic                       in_load;
    logic signed [DIFF_W-1:0]   diff;
    logic [PIXEL_W-1:0]         mag;
    logic signed [SQ_W+1:0]     sq_full;
    logic signed [SUM_W-1:0]    tot_ext;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    n_clamped;
    logic                       reg_write;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= METRIC_MANHATTAN;
        end else if (reg_write && (paddr[2] == REG_METRIC)) begin
            r_metric <= t_metric'(pwdata[METRIC_W-1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_METRIC) begin
            prdata = DATA_W'(r_metric);
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Only the last pair of a vector needs the output
    // register, so other pairs keep flowing while a result waits.
    // ------------------------------------------------------------------
    assign out_free   = !r_out_v || !i_out_stall;
    assign term_take  = r_term_v && (!r_term.last || out_free);
    assign term_load  = !r_term_v || term_take;
    assign in_load    = !r_in_v || term_load;
    assign o_in_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_load) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in.pixel_a <= i_pixel_a;
            r_in.pixel_b <= i_pixel_b;
            r_in.last    <= i_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: difference, magnitude and square of one pair.
    // ------------------------------------------------------------------
    always_comb begin
        diff    = $signed({1'b0, r_in.pixel_a}) - $signed({1'b0, r_in.pixel_b});
        mag     = diff[DIFF_W-1] ? PIXEL_W'(-diff) : diff[PIXEL_W-1:0];
        sq_full = (SQ_W+2)'(diff) * (SQ_W+2)'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_v <= 1'b0;
        end else if (term_load) begin
            r_term_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (term_load && r_in_v) begin
            r_term.diff <= diff;
            r_term.mag  <= mag;
            r_term.sq   <= sq_full[SQ_W-1:0];
            r_term.last <= r_in.last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: fold the term into the running total and saturate.
    // ------------------------------------------------------------------
    always_comb begin
        tot_ext = SUM_W'(r_total);
        unique case (r_metric)
            METRIC_MANHATTAN: n_sum = tot_ext + $signed(SUM_W'(r_term.mag));
            METRIC_SIGNED:    n_sum = tot_ext + SUM_W'(r_term.diff);
            METRIC_SQUARED:   n_sum = tot_ext + $signed(SUM_W'(r_term.sq));
            METRIC_CHEBYSHEV: begin
                // A negative partial total from another metric is replaced.
                if ($signed(SUM_W'(r_term.mag)) > tot_ext) begin
                    n_sum = $signed(SUM_W'(r_term.mag));
                end else begin
                    n_sum = tot_ext;
                end
            end
            default:          n_sum = tot_ext;
        endcase

        priority if (n_sum > DIST_HIGH) begin
            n_clamped = DIST_HIGH;
        end else if (n_sum < DIST_LOW) begin
            n_clamped = DIST_LOW;
        end else begin
            n_clamped = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (term_take) begin
            if (r_term.last) begin
                r_total <= '0;
            end else begin
                r_total <= n_clamped[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= term_take && r_term.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (term_take && r_term.last) begin
            r_dist <= n_clamped[DIST_W-1:0];
        end
    end

    assign o_out_valid = r_out_v;
    assign o_distance  = r_dist;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_total) <= DIST_HIGH) && (SUM_W'(r_total) >= DIST_LOW))
        else $error("running total left the saturation range");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((SUM_W'(o_distance) <= DIST_HIGH) &&
                         (SUM_W'(o_distance) >= DIST_LOW)))
        else $error("distance outside the saturation range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (term_take && r_term.last) |=> (r_total == '0))
        else $error("running total not cleared after the last pair");

    a_last_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (term_take && r_term.last) |-> out_free)
        else $error("last pair consumed while a result was still waiting");

    a_stall_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_v && r_term_v && r_term.last && o_out_valid))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> tb/pvd_checker.sv
// ============================================================================
// pvd_checker
// Watches the configuration port and both streams of the pixel vector
// distance block. It keeps its own copy of the metric and the running total,
// predicts each distance when the last pair of a vector is transferred, and
// compares every distance transfer and every metric read against it.
// ============================================================================
`timescale 1ns / 100ps

module pvd_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [pvd_pkg::ADDR_W-1:0]          paddr,
    input  wire [pvd_pkg::DATA_W-1:0]          pwdata,
    input  wire [pvd_pkg::DATA_W-1:0]          prdata,
    input  wire                                pready,
    input  wire                                i_in_valid,
    input  wire                                i_in_stall,
    input  wire [pvd_pkg::PIXEL_W-1:0]         i_pixel_a,
    input  wire [pvd_pkg::PIXEL_W-1:0]         i_pixel_b,
    input  wire                                i_last,
    input  wire                                i_out_valid,
    input  wire                                i_out_stall,
    input  wire signed [pvd_pkg::DIST_W-1:0]   i_distance,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    import pvd_pkg::*;

    localparam int DIST_MAX = MAX_LEN * 65025;
    localparam int DIST_MIN = -(MAX_LEN * 255);

    typedef logic signed [DIST_W-1:0] t_distance;

    t_metric   metric_now;
    int        total_now;
    t_distance distance_q[$];
    t_distance expected;
    int        fails;
    int        checked;

    // Folds one pixel pair into the running total under the given metric and
    // holds the total inside the output range.
    function automatic int fold_pair(t_metric m, int acc, logic [PIXEL_W-1:0] a,
                                     logic [PIXEL_W-1:0] b);
        int diff;
        int mag;
        int t;
        diff = int'(a) - int'(b);
        mag  = (diff < 0) ? -diff : diff;
        t    = acc;
        case (m)
            METRIC_MANHATTAN: t = t + mag;
            METRIC_SIGNED:    t = t + diff;
            METRIC_SQUARED:   t = t + diff * diff;
            default: begin
                if (mag > t) t = mag;
            end
        endcase
        if (t > DIST_MAX) t = DIST_MAX;
        if (t < DIST_MIN) t = DIST_MIN;
        return t;
    endfunction

    function automatic void note_failure(string what, int exp_val, int act_val);
        if (fails < 10) begin
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_val, act_val);
        end
        fails++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            metric_now = METRIC_MANHATTAN;
            total_now  = 0;
            distance_q.delete();
            fails      = 0;
            checked    = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                total_now = fold_pair(metric_now, total_now, i_pixel_a, i_pixel_b);
                if (i_last) begin
                    distance_q.push_back(t_distance'(total_now));
                    total_now = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (distance_q.size() == 0) begin
                    note_failure("distance transfer with nothing outstanding", 0,
                                 int'(i_distance));
                end else begin
                    expected = distance_q.pop_front();
                    if (i_distance !== expected) begin
                        note_failure("distance mismatch", int'(expected), int'(i_distance));
                    end
                    checked++;
                end
            end
            if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_METRIC) begin
                if (pwrite) begin
                    metric_now = t_metric'(pwdata[METRIC_W-1:0]);
                end else if (prdata !== DATA_W'(metric_now)) begin
                    note_failure("metric register read", int'(metric_now), int'(prdata));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= distance_q.size();
        o_checked    <= checked;
    end

endmodule

>>> tb/tb_top.sv
// ============================================================================
// tb_top
// Drives pixel pair vectors into the distance block under all four metrics,
// with short directed vectors first and then random vectors of mixed length,
// bursty input and random output stalls. Metric writes land between vectors
// and in the middle of them. The checker beside the block does the comparing.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
    import pvd_pkg::*;

    localparam logic [ADDR_W-1:0] METRIC_ADDR = {REG_METRIC, 2'b00};
    localparam int RANDOM_PAIRS = 1600;
    // Margin after the pipeline drains, before touching the metric register.
    localparam int DRAIN_CYCLES = 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [PIXEL_W-1:0]   i_pixel_a;
    logic [PIXEL_W-1:0]   i_pixel_b;
    logic                 i_last;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [DIST_W-1:0] o_distance;

    int fail_count;
    int pending;
    int checked;

    int pairs_sent;
    int vectors_sent;
    int metric_writes;
    int long_vectors;
    int burst_left;
    int target;
    int vec_len;
    int pick;
    int k;
    bit flip;
    bit long_vector;
    logic [PIXEL_W-1:0] pa;
    logic [PIXEL_W-1:0] pb;

    pixel_vector_distance_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pixel_a  (i_pixel_a),
        .i_pixel_b  (i_pixel_b),
        .i_last     (i_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_distance (o_distance)
    );

    pvd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_pixel_a   (i_pixel_a),
        .i_pixel_b   (i_pixel_b),
        .i_last      (i_last),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_distance  (o_distance),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

    // The receiver switches between stall patterns after a random span.
    initial begin : out_stall_pattern
        int mode;
        int span;
        int cyc;
        i_out_stall = 1'b0;
        cyc = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge i_clk);
                cyc++;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= cyc[2];
                endcase
            end
        end
    end

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pair(input logic [PIXEL_W-1:0] a, input logic [PIXEL_W-1:0] b,
                             input logic is_last);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_pixel_a  <= a;
        i_pixel_b  <= b;
        i_last     <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        pairs_sent++;
    endtask

    // Idle cycles on the input; the payload wanders while valid is low.
    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_pixel_a  <= PIXEL_W'($urandom);
            i_pixel_b  <= PIXEL_W'($urandom);
            i_last     <= 1'($urandom);
        end
    endtask

    task automatic wait_for_drain();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The upper write bits are junk on purpose; only the metric field is kept.
    task automatic set_metric(input t_metric m);
        pause_sender(1);
        wait_for_drain();
        apb_access(1'b1, METRIC_ADDR, {30'($urandom), m});
        apb_access(1'b0, METRIC_ADDR, '0);
        metric_writes++;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_pixel_a   = '0;
        i_pixel_b   = '0;
        i_last      = 1'b0;
        pairs_sent    = 0;
        vectors_sent  = 0;
        metric_writes = 0;
        long_vectors  = 0;
        burst_left    = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The metric must read back as Manhattan out of reset.
        apb_access(1'b0, METRIC_ADDR, '0);
        send_pair(8'd255, 8'd0, 1'b1);
        send_pair(8'd0, 8'd255, 1'b1);
        send_pair(8'd0, 8'd0, 1'b1);

        set_metric(METRIC_SIGNED);
        send_pair(8'd0, 8'd255, 1'b1);
        send_pair(8'd255, 8'd0, 1'b0);
        send_pair(8'd17, 8'd200, 1'b1);

        set_metric(METRIC_SQUARED);
        send_pair(8'd255, 8'd0, 1'b1);
        send_pair(8'd0, 8'd255, 1'b0);
        send_pair(8'd128, 8'd127, 1'b1);

        set_metric(METRIC_CHEBYSHEV);
        send_pair(8'd3, 8'd10, 1'b0);
        send_pair(8'd200, 8'd100, 1'b1);
        send_pair(8'd5, 8'd5, 1'b1);

        // Chebyshev replaces a negative partial total left by the signed sum.
        set_metric(METRIC_SIGNED);
        send_pair(8'd0, 8'd255, 1'b0);
        set_metric(METRIC_CHEBYSHEV);
        send_pair(8'd10, 8'd10, 1'b1);

        // Metric switched mid-vector without restarting the total.
        set_metric(METRIC_SQUARED);
        send_pair(8'd10, 8'd0, 1'b0);
        set_metric(METRIC_MANHATTAN);
        send_pair(8'd0, 8'd5, 1'b1);
        vectors_sent = 11;

        target = pairs_sent + RANDOM_PAIRS;
        while (pairs_sent < target) begin
            if ($urandom_range(0, 19) == 0) set_metric(t_metric'($urandom_range(0, 3)));
            pick = $urandom_range(0, 15);
            long_vector = (pick == 0);
            if (long_vector) begin
                vec_len = $urandom_range(65, 90);
                long_vectors++;
            end else if (pick < 4) begin
                vec_len = $urandom_range(7, 30);
            end else begin
                vec_len = $urandom_range(1, 6);
            end
            flip = 1'($urandom);
            for (k = 0; k < vec_len; k++) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
                    burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
                end
                burst_left--;
                if (k + 1 < vec_len && $urandom_range(0, 79) == 0) begin
                    set_metric(t_metric'($urandom_range(0, 3)));
                end
                // Long vectors lean on full-scale differences to hit the range limits.
                if (long_vector && $urandom_range(0, 3) != 0) begin
                    pa = flip ? 8'd0 : 8'd255;
                    pb = flip ? 8'd255 : 8'd0;
                end else begin
                    pa = rand_pixel();
                    pb = rand_pixel();
                end
                send_pair(pa, pb, k + 1 == vec_len);
            end
            vectors_sent++;
        end

        pause_sender(1);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d pairs in %0d vectors (%0d long enough to saturate), %0d metric writes.",
                 pairs_sent, vectors_sent, long_vectors, metric_writes);
        $display("Compared %0d distances over all four metrics, with mid-vector metric changes.",
                 checked);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
